FILE: hdl/tlvp_pkg.sv
// Shared types and constants of the TLV stream parser.
`timescale 1ns / 1ps

package tlvp_pkg;

  // Default buffer size limit; bytes at or beyond it count as truncation.
  localparam int unsigned MAX_BUFFER_BYTES_DEFAULT = 65536;

  // Reset value of the max_entries register.
  localparam logic [7:0] MAX_ENTRIES_RESET = 8'd16;

  // Result kinds.
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Stop reasons reported in the summary.
  localparam logic [1:0] STOP_END_OF_DATA = 2'd0;
  localparam logic [1:0] STOP_ENTRY_LIMIT = 2'd1;
  localparam logic [1:0] STOP_TRUNCATED   = 2'd2;
  localparam logic [1:0] STOP_ZERO_LENGTH = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rtype;
    logic [14:0] length;
    logic [15:0] offset;
    logic [7:0]  count;
    logic [1:0]  reason;
    logic        last;
  } result_t;

  // Results produced by one byte: at most a record and a summary, in that order.
  typedef struct packed {
    logic    rec_valid;
    result_t rec;
    logic    sum_valid;
    result_t sum;
  } result_pair_t;

endpackage

FILE: hdl/tlvp_core.sv
// Parse state of the TLV stream parser: advances one byte per transfer.
`timescale 1ns / 1ps

module tlvp_core #(
  parameter int unsigned MAX_BUFFER_BYTES = tlvp_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic [7:0]            max_entries,
  output tlvp_pkg::result_pair_t results
);

  localparam int PW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_BUFFER_BYTES);

  localparam logic [2:0] PH_TYPE  = 3'd0;
  localparam logic [2:0] PH_LEN1  = 3'd1;
  localparam logic [2:0] PH_LEN2  = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_HALT  = 3'd4;

  logic [2:0]    phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]    done, done_next;
  logic [7:0]    cur_type, cur_type_next;
  logic [6:0]    len_hi, len_hi_next;
  logic [14:0]   cur_len, cur_len_next;
  logic [14:0]   remaining, remaining_next;
  logic [15:0]   value_start, value_start_next;
  logic [1:0]    halt_reason, halt_reason_next;

  logic [2:0]  phase_eff;
  logic        start_value;
  logic [14:0] new_len;
  logic [7:0]  done_inc;
  logic [31:0] pos_plus;
  logic [1:0]  sum_reason;

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    done_next        = done;
    cur_type_next    = cur_type;
    len_hi_next      = len_hi;
    cur_len_next     = cur_len;
    remaining_next   = remaining;
    value_start_next = value_start;
    halt_reason_next = halt_reason;
    start_value      = 1'b0;
    new_len          = 15'd0;
    done_inc         = done + 8'd1;
    pos_plus         = 32'(pos) + 32'd1;
    sum_reason       = tlvp_pkg::STOP_END_OF_DATA;
    results          = '0;

    // Checks made before the byte is used.
    phase_eff = phase;
    if (phase_eff != PH_HALT && pos >= POS_LIMIT) begin
      phase_eff        = PH_HALT;
      halt_reason_next = tlvp_pkg::STOP_TRUNCATED;
    end
    if (phase_eff == PH_TYPE && done >= max_entries) begin
      phase_eff        = PH_HALT;
      halt_reason_next = tlvp_pkg::STOP_ENTRY_LIMIT;
    end
    phase_next = phase_eff;

    case (phase_eff)
      PH_TYPE: begin
        cur_type_next = data_byte;
        phase_next    = PH_LEN1;
      end
      PH_LEN1: begin
        if (data_byte[7]) begin
          len_hi_next = data_byte[6:0];
          phase_next  = PH_LEN2;
        end else begin
          start_value = 1'b1;
          new_len     = {8'd0, data_byte[6:0]};
        end
      end
      PH_LEN2: begin
        start_value = 1'b1;
        new_len     = {len_hi, data_byte};
      end
      PH_VALUE: begin
        remaining_next = remaining - 15'd1;
        if (remaining == 15'd1) begin
          results.rec_valid  = 1'b1;
          results.rec.kind   = tlvp_pkg::KIND_RECORD;
          results.rec.rtype  = cur_type;
          results.rec.length = cur_len;
          results.rec.offset = value_start;
          results.rec.count  = done;
          done_next          = done_inc;
          phase_next         = PH_TYPE;
          if (done_inc >= max_entries) begin
            phase_next       = PH_HALT;
            halt_reason_next = tlvp_pkg::STOP_ENTRY_LIMIT;
          end
        end
      end
      default: begin
      end
    endcase

    if (start_value) begin
      cur_len_next = new_len;
      if (new_len == 15'd0) begin
        phase_next       = PH_HALT;
        halt_reason_next = tlvp_pkg::STOP_ZERO_LENGTH;
      end else begin
        remaining_next   = new_len;
        value_start_next = pos_plus[15:0];
        phase_next       = PH_VALUE;
      end
    end

    if (pos < POS_LIMIT) begin
      pos_next = PW'(pos_plus);
    end

    if (last_byte) begin
      if (phase_next == PH_HALT) begin
        sum_reason = halt_reason_next;
      end else if (phase_next == PH_TYPE) begin
        sum_reason = tlvp_pkg::STOP_END_OF_DATA;
      end else begin
        sum_reason = tlvp_pkg::STOP_TRUNCATED;
      end
      results.sum_valid  = 1'b1;
      results.sum.kind   = tlvp_pkg::KIND_SUMMARY;
      results.sum.count  = done_next;
      results.sum.reason = sum_reason;
      results.sum.last   = 1'b1;
      // Rearm for the next buffer.
      phase_next       = PH_TYPE;
      pos_next         = '0;
      done_next        = 8'd0;
      cur_type_next    = 8'd0;
      len_hi_next      = 7'd0;
      cur_len_next     = 15'd0;
      remaining_next   = 15'd0;
      value_start_next = 16'd0;
      halt_reason_next = tlvp_pkg::STOP_END_OF_DATA;
    end

    // Nothing is produced unless a byte is actually transferred.
    if (!accept) begin
      results = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      pos         <= '0;
      done        <= 8'd0;
      cur_type    <= 8'd0;
      len_hi      <= 7'd0;
      cur_len     <= 15'd0;
      remaining   <= 15'd0;
      value_start <= 16'd0;
      halt_reason <= tlvp_pkg::STOP_END_OF_DATA;
    end else if (accept) begin
      phase       <= phase_next;
      pos         <= pos_next;
      done        <= done_next;
      cur_type    <= cur_type_next;
      len_hi      <= len_hi_next;
      cur_len     <= cur_len_next;
      remaining   <= remaining_next;
      value_start <= value_start_next;
      halt_reason <= halt_reason_next;
    end
  end

  a_rearm_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> phase == PH_TYPE && pos == '0 && done == 8'd0)
    else $error("parser did not rearm after the final byte");

  a_record_in_value: assert property (@(posedge clk) disable iff (rst)
    results.rec_valid |-> phase == PH_VALUE && remaining == 15'd1)
    else $error("record reported outside the value phase");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LIMIT)
    else $error("byte position ran past the buffer limit");

  a_value_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_VALUE |-> remaining != 15'd0)
    else $error("value phase entered with nothing remaining");

endmodule

FILE: hdl/tlvp_out_fifo.sv
// Result queue of the TLV stream parser: takes up to two results, sends one per transfer.
`timescale 1ns / 1ps

module tlvp_out_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  tlvp_pkg::result_pair_t push,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tlvp_pkg::result_t      head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  tlvp_pkg::result_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count, count_next;

  tlvp_pkg::result_t first, second;
  logic [1:0]  n_push;
  logic        pop;
  logic [AW-1:0] wr_ptr1;

  always_comb begin
    first   = push.rec_valid ? push.rec : push.sum;
    second  = push.sum;
    n_push  = 2'(push.rec_valid) + 2'(push.sum_valid);
    pop     = out_valid && out_ready;
    wr_ptr1 = wr_ptr + AW'(1);
    count_next = count + (AW+1)'(n_push) - (AW+1)'(pop);
  end

  // Room for the worst case of one byte: a record and a summary.
  assign space     = count <= (AW+1)'(DEPTH - 2);
  assign out_valid = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= first;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr1] <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_space: assert property (@(posedge clk) disable iff (rst)
    n_push != 2'd0 |-> space)
    else $error("results pushed without room in the queue");

endmodule

FILE: hdl/tlv_stream_parser.sv
// Top level of the TLV stream parser.
`timescale 1ns / 1ps

// Parses type-length-value records from a byte stream, one byte per transfer on
// the input channel with last_byte set on the final byte of a buffer. Each
// complete record yields one result; the final byte also yields a summary with
// the record count and stop reason, so that byte can give two results. Every
// byte is handled in the cycle it is taken, so the block accepts one byte per
// cycle, held off only while fewer than two queue entries are free; results
// leave a four-entry queue, one per cycle with out_ready high. The user must
// write max_entries via cfg_wr_en/cfg_wr_data with no buffer open; unenforced.
module tlv_stream_parser #(
  parameter int unsigned MAX_BUFFER_BYTES = tlvp_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  record_type,
  output logic [14:0] record_length,
  output logic [15:0] value_offset,
  output logic [7:0]  record_count,
  output logic [1:0]  stop_reason,
  output logic        last,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0]             max_entries;
  logic                   accept;
  tlvp_pkg::result_pair_t results;
  tlvp_pkg::result_t      head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= tlvp_pkg::MAX_ENTRIES_RESET;
    end else if (cfg_wr_en) begin
      max_entries <= cfg_wr_data;
    end
  end

  assign accept = in_valid && in_ready;

  tlvp_core #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .max_entries(max_entries),
    .results    (results)
  );

  tlvp_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (results),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign result_kind   = head.kind;
  assign record_type   = head.rtype;
  assign record_length = head.length;
  assign value_offset  = head.offset;
  assign record_count  = head.count;
  assign stop_reason   = head.reason;
  assign last          = head.last;

endmodule

FILE: tb/tlv_stream_parser_test.sv
// Self-checking testbench for the TLV stream parser with its own record parser model.
`timescale 1ns / 1ps

module tlv_stream_parser_test;

  // A small buffer limit keeps oversized buffers short.
  localparam int unsigned BUF_LIMIT = 256;

  typedef enum logic [2:0] {AT_TYPE, AT_LEN, AT_LEN_LOW, AT_VALUE, HALTED} parse_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  record_type;
  logic [14:0] record_length;
  logic [15:0] value_offset;
  logic [7:0]  record_count;
  logic [1:0]  stop_reason;
  logic        last;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        hold_req = 1'b0;

  // Parser model state.
  parse_phase_t phase;
  logic [16:0]  position;
  logic [7:0]   done_count;
  logic [7:0]   rec_type;
  logic [6:0]   len_high;
  logic [14:0]  rec_len;
  logic [14:0]  remaining;
  logic [16:0]  value_at;
  logic [1:0]   halt_why;
  logic [7:0]   entry_limit;

  tlvp_pkg::result_t owed_results[$];
  stream_byte_t      byte_stream[$];
  logic [7:0]        frame[$];
  int                bytes_queued = 0;
  int                bytes_taken = 0;
  int                mismatches = 0;

  tlv_stream_parser #(
    .MAX_BUFFER_BYTES(BUF_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .record_type(record_type),
    .record_length(record_length),
    .value_offset(value_offset),
    .record_count(record_count),
    .stop_reason(stop_reason),
    .last(last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic string show_result(input tlvp_pkg::result_t r);
    return $sformatf("kind=%0d type=%0d len=%0d off=%0d count=%0d reason=%0d last=%0d",
                     r.kind, r.rtype, r.length, r.offset, r.count, r.reason, r.last);
  endfunction

  task automatic clear_buffer_state();
    phase = AT_TYPE;
    position = '0;
    done_count = '0;
    rec_type = '0;
    len_high = '0;
    rec_len = '0;
    remaining = '0;
    value_at = '0;
    halt_why = tlvp_pkg::STOP_END_OF_DATA;
  endtask

  task automatic stop_parsing(input logic [1:0] why);
    phase = HALTED;
    halt_why = why;
  endtask

  // Advances the parser model by one byte and queues the results it owes.
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    tlvp_pkg::result_t r;
    logic [14:0]       len;
    logic              got_len;
    got_len = 1'b0;
    len = '0;
    if (phase != HALTED && position >= BUF_LIMIT)
      stop_parsing(tlvp_pkg::STOP_TRUNCATED);
    if (phase == AT_TYPE && done_count >= entry_limit)
      stop_parsing(tlvp_pkg::STOP_ENTRY_LIMIT);
    case (phase)
      AT_TYPE: begin
        rec_type = b;
        phase = AT_LEN;
      end
      AT_LEN: begin
        if (b[7]) begin
          len_high = b[6:0];
          phase = AT_LEN_LOW;
        end else begin
          len = {8'd0, b[6:0]};
          got_len = 1'b1;
        end
      end
      AT_LEN_LOW: begin
        len = {len_high, b};
        got_len = 1'b1;
      end
      AT_VALUE: begin
        remaining = remaining - 15'd1;
        if (remaining == '0) begin
          r = '0;
          r.kind = tlvp_pkg::KIND_RECORD;
          r.rtype = rec_type;
          r.length = rec_len;
          r.offset = value_at[15:0];
          r.count = done_count;
          owed_results.push_back(r);
          done_count = done_count + 8'd1;
          phase = AT_TYPE;
          if (done_count >= entry_limit) stop_parsing(tlvp_pkg::STOP_ENTRY_LIMIT);
        end
      end
      default: ;
    endcase
    if (got_len) begin
      rec_len = len;
      if (len == '0) begin
        stop_parsing(tlvp_pkg::STOP_ZERO_LENGTH);
      end else begin
        remaining = len;
        value_at = position + 17'd1;
        phase = AT_VALUE;
      end
    end
    if (position < BUF_LIMIT) position = position + 17'd1;
    if (fin) begin
      r = '0;
      r.kind = tlvp_pkg::KIND_SUMMARY;
      r.count = done_count;
      r.last = 1'b1;
      if (phase == HALTED) r.reason = halt_why;
      else if (phase == AT_TYPE) r.reason = tlvp_pkg::STOP_END_OF_DATA;
      else r.reason = tlvp_pkg::STOP_TRUNCATED;
      owed_results.push_back(r);
      clear_buffer_state();
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int           gap_left = 0;
  int           burst_left = 0;
  stream_byte_t nxt_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(data_byte, last_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || byte_stream.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          nxt_item = byte_stream.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt_item.data;
          last_byte <= nxt_item.fin;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 23);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls on a changing bit pattern,
  // or for a long stretch when asked to.
  tlvp_pkg::result_t seen;
  tlvp_pkg::result_t want;
  int                hold_left = 0;
  int                pat_age = 0;
  logic [7:0]        pat = 8'hFF;
  logic [2:0]        pat_idx = '0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      pat_age <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {result_kind, record_type, record_length, value_offset, record_count,
                stop_reason, last};
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show_result(seen));
        end else begin
          want = owed_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch\n  expected %s\n  actual   %s",
                       show_result(want), show_result(seen));
          end
        end
      end
      if (hold_req) hold_left <= 120;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      if (pat_age == 0) begin
        pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        pat_age <= 40;
      end else begin
        pat_age <= pat_age - 1;
      end
      pat_idx <= pat_idx + 3'd1;
      out_ready <= !hold_req && hold_left <= 1 && pat[pat_idx];
    end
  end

  task automatic send_frame();
    stream_byte_t it;
    foreach (frame[i]) begin
      it.data = frame[i];
      it.fin = (i == frame.size() - 1);
      byte_stream.push_back(it);
    end
    bytes_queued += frame.size();
    frame.delete();
  endtask

  task automatic add_record(input logic [7:0] rtype, input logic [14:0] len,
                            input bit long_form);
    frame.push_back(rtype);
    if (long_form || len > 15'd127) begin
      frame.push_back({1'b1, len[14:8]});
      frame.push_back(len[7:0]);
    end else begin
      frame.push_back({1'b0, len[6:0]});
    end
    repeat (len) frame.push_back(8'($urandom));
  endtask

  function automatic logic [14:0] rand_len();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 15'($urandom_range(30, 100));
    if (sel < 4) return 15'($urandom_range(7, 40));
    return 15'($urandom_range(1, 6));
  endfunction

  // Mostly well-formed buffers; some end early, hit a zero length or are plain noise.
  task automatic random_frame();
    int kind;
    int cut;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 5))
        add_record(8'($urandom), rand_len(), $urandom_range(0, 3) == 0);
      if (kind == 1) add_record(8'($urandom), '0, $urandom_range(0, 1) == 1);
      if (kind <= 2) repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom));
      if (frame.size() == 0) frame.push_back(8'($urandom));
      if (kind == 3) begin
        cut = $urandom_range(1, frame.size());
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end
  endtask

  // Waits until every byte has gone in and every result has come out, or until the wait for results times out.
  task automatic drain();
    int waited;
    waited = 0;
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (owed_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    entry_limit = v;
  endtask

  initial begin
    int         phase_bytes;
    logic [7:0] limits[8];
    limits = '{8'd255, 8'd1, 8'd2, 8'd255, 8'd4, 8'($urandom_range(3, 255)), 8'd8, 8'd16};
    entry_limit = tlvp_pkg::MAX_ENTRIES_RESET;
    clear_buffer_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Clean ends, long length form, zero lengths and buffers cut short.
    frame = '{8'hFF, 8'h01, 8'hAA};               send_frame();
    frame = '{8'h00, 8'h80, 8'h02, 8'h5A, 8'hC3}; send_frame();
    frame = '{8'h12, 8'h00, 8'h34};               send_frame();
    frame = '{8'h12, 8'h80, 8'h00};               send_frame();
    frame = '{8'h55};                             send_frame();
    frame = '{8'h01, 8'hFF};                      send_frame();
    frame = '{8'h01, 8'h03, 8'h77};               send_frame();
    drain();
    // The final byte completes the record that reaches the limit.
    write_limit(8'd1);
    frame = '{8'h01, 8'h01, 8'h0F};               send_frame();
    drain();
    // No records allowed at all.
    write_limit(8'd0);
    frame = '{8'h42};                             send_frame();
    drain();

    // One long record, then a maximum-length header whose value runs past the buffer size.
    write_limit(8'd16);
    add_record(8'hA5, 15'd250, 1'b1);
    frame.push_back(8'h5A);
    frame.push_back(8'hFF);
    frame.push_back(8'hFF);
    repeat (6) frame.push_back(8'($urandom));
    send_frame();
    drain();

    foreach (limits[p]) begin
      write_limit(limits[p]);
      phase_bytes = 0;
      if (p == 3) begin
        // Short records while the receiver holds off, so the result queue fills.
        repeat (20) add_record(8'($urandom), 15'd1, 1'b0);
        phase_bytes += frame.size();
        send_frame();
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      while (phase_bytes < 16) begin
        random_frame();
        phase_bytes += frame.size();
        send_frame();
      end
      drain();
    end

    mismatches += owed_results.size();
    if (mismatches == 0) begin
      $display("** tlv_stream_parser: PASSED **");
    end else begin
      $display("** tlv_stream_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** tlv_stream_parser: FAILED **");
    $finish;
  end

endmodule
